// ----- design/idpr_pkg.sv -----
// Shared types, codes and constants of the dot product and requantize block.
package idpr_pkg;

  // Field widths
  localparam int ACT_W   = 16;
  localparam int WGT_W   = 12;
  localparam int RAW_W   = 32;
  localparam int BIAS_W  = 48;
  localparam int SCALE_W = 47;
  localparam int OUT_W   = 16;

  // Scale is split into two slices so each product stays within 32 x 24 bits
  localparam int SLO_W  = 24;
  localparam int MULB_W = 24;
  localparam int MULP_W = RAW_W + MULB_W;   // 56-bit partial product
  localparam int PROD_W = MULP_W + SLO_W;   // 80-bit full product
  localparam int T_W    = 65;               // biased Q30 value, signed
  localparam int MAG_W  = 64;

  // Requantization constants
  localparam logic [OUT_W-1:0] QMAX     = 16'd32767;
  localparam logic [MAG_W:0]   HALF_Q30 = 65'd536870912;
  localparam int               FRAC_SH  = 30;
  localparam int               LIM_BIT  = 62;   // product limit is 2^62

  // Item modes
  localparam logic MODE_MAC = 1'b0;
  localparam logic MODE_REQ = 1'b1;

  // Result kinds
  localparam logic KIND_RAW = 1'b0;
  localparam logic KIND_Q15 = 1'b1;

  // One classified item as held in the queue between front and back
  typedef struct packed {
    logic                     mode;
    logic                     last_term;
    logic signed [ACT_W-1:0]  act_q15;
    logic signed [WGT_W-1:0]  weight_q12;
    logic                     raw_neg;
    logic [RAW_W-1:0]         raw_mag;
    logic signed [BIAS_W-1:0] bias_q30;
  } idpr_item_t;

endpackage

// ----- design/idpr_front.sv -----
// Input side: accepts items, splits the raw sum into sign and magnitude, queues them.
module idpr_front import idpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic signed [ACT_W-1:0]  in_act_q15,
  input  logic signed [WGT_W-1:0]  in_weight_q12,
  input  logic                     in_last_term,
  input  logic signed [RAW_W-1:0]  in_raw_in,
  input  logic signed [BIAS_W-1:0] in_bias_q30,
  output logic                     q_valid,
  input  logic                     q_ready,
  output idpr_item_t               q_item
);

  idpr_item_t q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  idpr_item_t item;
  logic       push;
  logic       pop;

  // Classify the incoming item
  always_comb begin
    item            = '0;
    item.mode       = in_mode;
    item.last_term  = in_last_term;
    item.act_q15    = in_act_q15;
    item.weight_q12 = in_weight_q12;
    item.raw_neg    = in_raw_in[RAW_W-1];
    item.raw_mag    = in_raw_in[RAW_W-1] ? RAW_W'(-in_raw_in) : RAW_W'(in_raw_in);
    item.bias_q30   = in_bias_q30;
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = q_mem_r[rd_ptr_r];

  // Two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- design/idpr_back.sv -----
// Execution side: MAC with saturating accumulator and multi-cycle requantizer.
module idpr_back import idpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  idpr_item_t               q_item,
  input  logic [SCALE_W-1:0]       scale_q30,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic signed [RAW_W-1:0]  out_raw_sum,
  output logic signed [OUT_W-1:0]  out_q15,
  output logic                     out_overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_MUL_HI,
    S_SUM,
    S_BIAS,
    S_MAG,
    S_OUT
  } state_t;

  localparam logic signed [RAW_W+1:0] SUM_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [RAW_W+1:0] SUM_MIN = -34'sh0_8000_0000;

  state_t                    state_r;
  idpr_item_t                op_r;
  logic signed [RAW_W-1:0]   acc_r;
  logic                      sat_r;
  logic signed [27:0]        mprod_r;
  logic [MULP_W-1:0]         plo_r;
  logic [MULP_W-1:0]         phi_r;
  logic [PROD_W-1:0]         prod_r;
  logic signed [T_W-1:0]     t_r;
  logic                      big_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;
  logic                      out_valid_r;
  logic                      kind_r;
  logic signed [RAW_W-1:0]   raw_sum_r;
  logic signed [OUT_W-1:0]   q15_r;
  logic                      ovf_r;

  logic                      out_free;
  logic                      out_load;
  logic [RAW_W-1:0]          mul_a;
  logic [MULB_W-1:0]         mul_b;
  logic [MULP_W-1:0]         mul_p;
  logic signed [27:0]        mac_p;
  logic signed [RAW_W+1:0]   sum_w;
  logic signed [RAW_W-1:0]   sum_sat;
  logic                      sum_ovf;
  logic                      big;
  logic signed [T_W-1:0]     pmag_s;
  logic signed [T_W-1:0]     bias_s;
  logic [MAG_W:0]            rnd;
  logic [MAG_W-FRAC_SH:0]    qv;
  logic [OUT_W-1:0]          qmag;
  logic signed [OUT_W-1:0]   q_final;

  assign out_free = !out_valid_r || out_ready;
  assign q_ready  = (state_r == S_IDLE);

  // A result leaves the sequencer on a last MAC term or at the end of a requantize
  assign out_load = out_free &&
                    (((state_r == S_MAC) && op_r.last_term) || (state_r == S_OUT));

  // Shared 32 x 24 multiplier: low scale slice on pop, high slice next cycle
  always_comb begin
    if (state_r == S_IDLE) begin
      mul_a = q_item.raw_mag;
      mul_b = scale_q30[SLO_W-1:0];
    end else begin
      mul_a = op_r.raw_mag;
      mul_b = {1'b0, scale_q30[SCALE_W-1:SLO_W]};
    end
    mul_p = MULP_W'(mul_a) * MULP_W'(mul_b);
  end

  // Activation times weight
  assign mac_p = 28'(q_item.act_q15) * 28'(q_item.weight_q12);

  // Saturating accumulate
  always_comb begin
    sum_w   = 34'(acc_r) + 34'(mprod_r);
    sum_ovf = 1'b0;
    if (sum_w > SUM_MAX) begin
      sum_sat = RAW_W'(SUM_MAX);
      sum_ovf = 1'b1;
    end else if (sum_w < SUM_MIN) begin
      sum_sat = RAW_W'(SUM_MIN);
      sum_ovf = 1'b1;
    end else begin
      sum_sat = RAW_W'(sum_w);
    end
  end

  // Product limit check and bias add
  always_comb begin
    big    = (|prod_r[PROD_W-1:LIM_BIT+1]) ||
             (prod_r[LIM_BIT] && (|prod_r[LIM_BIT-1:0]));
    pmag_s = T_W'(prod_r[LIM_BIT:0]);
    bias_s = T_W'(op_r.bias_q30);
  end

  // Round half away from zero, drop Q30 fraction, clamp
  always_comb begin
    rnd  = {1'b0, mag_r} + HALF_Q30;
    qv   = rnd[MAG_W:FRAC_SH];
    qmag = (qv > (MAG_W-FRAC_SH+1)'(QMAX)) ? QMAX : qv[OUT_W-1:0];
    if (big_r) begin
      q_final = op_r.raw_neg ? -$signed(QMAX) : $signed(QMAX);
    end else begin
      q_final = neg_r ? -$signed(qmag) : $signed(qmag);
    end
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Result valid: set when loaded, cleared on transfer
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            op_r    <= q_item;
            mprod_r <= mac_p;
            plo_r   <= mul_p;
            state_r <= (q_item.mode == MODE_MAC) ? S_MAC : S_MUL_HI;
          end
        end
        S_MAC: begin
          if (!op_r.last_term) begin
            acc_r   <= sum_sat;
            sat_r   <= sat_r | sum_ovf;
            state_r <= S_IDLE;
          end else if (out_free) begin
            kind_r      <= KIND_RAW;
            raw_sum_r   <= sum_sat;
            q15_r       <= '0;
            ovf_r       <= sat_r | sum_ovf;
            acc_r       <= '0;
            sat_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_MUL_HI: begin
          phi_r   <= mul_p;
          state_r <= S_SUM;
        end
        S_SUM: begin
          prod_r  <= {phi_r, SLO_W'(0)} + PROD_W'(plo_r);
          state_r <= S_BIAS;
        end
        S_BIAS: begin
          big_r   <= big;
          t_r     <= op_r.raw_neg ? (bias_s - pmag_s) : (bias_s + pmag_s);
          state_r <= S_MAG;
        end
        S_MAG: begin
          neg_r   <= t_r[T_W-1];
          mag_r   <= t_r[T_W-1] ? MAG_W'(-t_r) : MAG_W'(t_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            kind_r      <= KIND_Q15;
            raw_sum_r   <= '0;
            q15_r       <= q_final;
            ovf_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_raw_sum     = raw_sum_r;
  assign out_q15         = q15_r;
  assign out_overflow    = ovf_r;

endmodule

// ----- design/int16_dot_product_requantize.sv -----
// A last MAC term passes from the queue through S_MAC to the output register; a requantize
// item passes through S_MUL_HI, S_SUM, S_BIAS, S_MAG and S_OUT. The back-end sequencer and its
// shared 32x24 multiplier take a new item only once idle; a 2-entry queue decouples input.
// Reset (synchronous, rst_n low): queue empty, accumulator and overflow flag cleared,
// scale_q30 set to 0, no result pending.
// Top level: scale register, front-end queue and back-end execution unit.
module int16_dot_product_requantize import idpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [SCALE_W-1:0]       cfg_scale_q30,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic signed [ACT_W-1:0]  in_act_q15,
  input  logic signed [WGT_W-1:0]  in_weight_q12,
  input  logic                     in_last_term,
  input  logic signed [RAW_W-1:0]  in_raw_in,
  input  logic signed [BIAS_W-1:0] in_bias_q30,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic signed [RAW_W-1:0]  out_raw_sum,
  output logic signed [OUT_W-1:0]  out_q15,
  output logic                     out_overflow
);

  logic [SCALE_W-1:0] scale_r;
  logic               q_valid;
  logic               q_ready;
  idpr_item_t         q_item;

  // Scale register, written on every config transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_scale_q30;
    end
  end

  idpr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_act_q15    (in_act_q15),
    .in_weight_q12 (in_weight_q12),
    .in_last_term  (in_last_term),
    .in_raw_in     (in_raw_in),
    .in_bias_q30   (in_bias_q30),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  idpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .scale_q30       (scale_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_raw_sum     (out_raw_sum),
    .out_q15         (out_q15),
    .out_overflow    (out_overflow)
  );

endmodule
